// File: rtl/acr_pkg.sv
// Shared types and constants for the ARP cache resolver.
// No dependencies; imported by acr_engine and the top level.
package acr_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int LEN_W     = 16;
    localparam int OP_W      = 16;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_OWN_IP      = 2'd0;
    localparam cfg_idx_t CFG_GATEWAY_IP  = 2'd2;
    localparam cfg_idx_t CFG_SUBNET_MASK = 2'd3;

    localparam logic [IP_W-1:0] OWN_IP_RST      = 32'h0000_0000;
    localparam logic [IP_W-1:0] GATEWAY_IP_RST  = 32'h0A00_0202;
    localparam logic [IP_W-1:0] SUBNET_MASK_RST = 32'hFFFF_FF00;

    localparam kind_t KIND_HIT   = 2'd0;
    localparam kind_t KIND_MISS  = 2'd1;
    localparam kind_t KIND_REPLY = 2'd2;

    localparam logic [LEN_W-1:0] ARP_MIN_LEN = 16'd28;
    localparam logic [OP_W-1:0]  OP_REQUEST  = 16'd1;

    typedef struct packed {
        logic [IP_W-1:0] own_ip;
        logic [IP_W-1:0] gateway_ip;
        logic [IP_W-1:0] subnet_mask;
    } acr_cfg_t;

    typedef struct packed {
        logic              action;
        logic [IP_W-1:0]   lookup_ip;
        logic [LEN_W-1:0]  pkt_length;
        logic [OP_W-1:0]   arp_opcode;
        logic [IP_W-1:0]   src_ip;
        logic [MAC_W-1:0]  src_mac;
        logic [IP_W-1:0]   tgt_ip;
    } acr_item_t;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } acr_res_t;

endpackage

// File: rtl/acr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/acr_engine.sv
// Scan sequencer for the ARP cache: valid bits, IP and MAC tables, one shared
// compare unit stepping through the entries. Depends on acr_pkg and acr_ram.
module acr_engine
    import acr_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  acr_item_t item,
    input  acr_cfg_t  cfg,
    output logic      busy,
    output acr_res_t  res
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic               state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               issued_all_reg, issued_all_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]      cmp_idx_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IP_W-1:0]    key_reg, key_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic               learn_reg, learn_next;
    logic               reply_reg, reply_next;
    acr_res_t           res_reg, res_next;

    logic [IP_W-1:0]  hop;
    logic             short_pkt;
    logic             is_reply;
    logic [IP_W-1:0]  rd_ip;
    logic [MAC_W-1:0] rd_mac;
    logic             ip_eq;
    logic             hit;
    logic             finish;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;

    assign hop = ((item.lookup_ip & cfg.subnet_mask) == (cfg.own_ip & cfg.subnet_mask))
               ? item.lookup_ip : cfg.gateway_ip;
    assign short_pkt = item.pkt_length < ARP_MIN_LEN;
    assign is_reply  = (item.arp_opcode == OP_REQUEST) && (item.tgt_ip == cfg.own_ip);

    acr_ram #(
        .WIDTH (IP_W),
        .DEPTH (ENTRIES)
    ) u_ip_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_ip)
    );

    acr_ram #(
        .WIDTH (MAC_W),
        .DEPTH (ENTRIES)
    ) u_mac_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (mac_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_mac)
    );

    assign ip_eq  = rd_ip == key_reg;
    assign hit    = cmp_vld_reg && (learn_reg ? (!valid_reg[cmp_idx_reg] || ip_eq)
                                              : (valid_reg[cmp_idx_reg] && ip_eq));
    assign finish = (state_reg == ST_SCAN) && cmp_vld_reg && (hit || (cmp_idx_reg == LAST));
    assign wr_en   = finish && learn_reg;
    assign wr_addr = hit ? cmp_idx_reg : '0;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issued_all_next = issued_all_reg;
        cmp_vld_next    = 1'b0;
        valid_next      = valid_reg;
        key_next        = key_reg;
        mac_next        = mac_reg;
        learn_next      = learn_reg;
        reply_next      = reply_reg;
        res_next        = res_reg;
        res_next.valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next        = '0;
                    issued_all_next = 1'b0;
                    learn_next      = item.action;
                    reply_next      = is_reply;
                    mac_next        = item.src_mac;
                    key_next        = item.action ? item.src_ip : hop;
                    if (!(item.action && short_pkt))
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next = !issued_all_reg;
                if (!issued_all_reg)
                begin
                    if (idx_reg == LAST)
                    begin
                        issued_all_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                if (finish)
                begin
                    state_next   = ST_IDLE;
                    cmp_vld_next = 1'b0;
                    res_next.ip  = key_reg;
                    if (learn_reg)
                    begin
                        valid_next[wr_addr] = 1'b1;
                        res_next.valid      = reply_reg;
                        res_next.kind       = KIND_REPLY;
                        res_next.mac        = mac_reg;
                    end
                    else
                    begin
                        res_next.valid = 1'b1;
                        res_next.kind  = hit ? KIND_HIT : KIND_MISS;
                        res_next.mac   = hit ? rd_mac : '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            issued_all_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            valid_reg      <= '0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issued_all_reg <= issued_all_next;
            cmp_vld_reg    <= cmp_vld_next;
            valid_reg      <= valid_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= idx_reg;
        key_reg      <= key_next;
        mac_reg      <= mac_next;
        learn_reg    <= learn_next;
        reply_reg    <= reply_next;
    end

    assign busy = state_reg != ST_IDLE;
    assign res  = res_reg;

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("valid bit cleared");

    a_one_learn: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg & ~$past(valid_reg)) <= 1))
        else $error("more than one entry learned at once");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SCAN) && learn_reg)
        else $error("table write outside a learn scan");

    a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && !learn_reg) |=> res_reg.valid)
        else $error("lookup finished without a result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        !finish |=> !res_reg.valid)
        else $error("result without a finished scan");

endmodule

// File: rtl/arp_cache_resolver_top.sv
// ARP cache resolver top level: configuration registers and port mapping.
// Depends on acr_pkg and acr_engine.
//
// Usage:
//   Command channel: drive the item fields and raise start; the word is taken
//   at a rising edge with start high and busy low. action 0 resolves
//   lookup_ip to a next hop and a MAC, action 1 learns a received ARP packet.
//   Result channel: result_valid is high for exactly one cycle with out_kind,
//   out_mac and out_ip; the receiver must take it then, it cannot stall.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 own_ip,
//   2 gateway_ip, 3 subnet_mask; 1 is ignored) at a clock edge. The user
//   writes only while the block is idle; the block does not enforce it.
//   Scan: one shared compare unit walks the table one entry per cycle
//   behind a registered RAM read. A word ends its scan at its matching
//   entry or at the last entry and shows its result as busy falls; a new
//   word is taken only while busy is low, so the block cannot take one
//   before it is through with the last. A learn packet shorter than 28
//   bytes is not scanned and gives no result.
//   Reset: clears all valid bits and loads the register defaults; the table
//   needs no clearing pass.
module arp_cache_resolver_top
    import acr_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [IP_W-1:0]   lookup_ip,
    input  logic [LEN_W-1:0]  pkt_length,
    input  logic [OP_W-1:0]   arp_opcode,
    input  logic [IP_W-1:0]   src_ip,
    input  logic [MAC_W-1:0]  src_mac,
    input  logic [IP_W-1:0]   tgt_ip,
    input  logic              cfg_we,
    input  cfg_idx_t          cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              result_valid,
    output kind_t             out_kind,
    output logic [MAC_W-1:0]  out_mac,
    output logic [IP_W-1:0]   out_ip
);

    acr_cfg_t  cfg_reg, cfg_next;
    acr_item_t item;
    acr_res_t  res;
    logic      eng_busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_IP:      cfg_next.own_ip      = cfg_data[IP_W-1:0];
                CFG_GATEWAY_IP:  cfg_next.gateway_ip  = cfg_data[IP_W-1:0];
                CFG_SUBNET_MASK: cfg_next.subnet_mask = cfg_data[IP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip      <= OWN_IP_RST;
            cfg_reg.gateway_ip  <= GATEWAY_IP_RST;
            cfg_reg.subnet_mask <= SUBNET_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign item.action     = action;
    assign item.lookup_ip  = lookup_ip;
    assign item.pkt_length = pkt_length;
    assign item.arp_opcode = arp_opcode;
    assign item.src_ip     = src_ip;
    assign item.src_mac    = src_mac;
    assign item.tgt_ip     = tgt_ip;

    acr_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !eng_busy),
        .item  (item),
        .cfg   (cfg_reg),
        .busy  (eng_busy),
        .res   (res)
    );

    assign busy         = eng_busy;
    assign result_valid = res.valid;
    assign out_kind     = res.kind;
    assign out_mac      = res.mac;
    assign out_ip       = res.ip;

endmodule
